[sv/skf_pkg.sv]
// Shared constants for the scalar Kalman smoother: widths, reset values, register indexes.
package skf_pkg;

    // default number format: signed/unsigned Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration port
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd2;

    // register reset values, truncated to DATA_WIDTH where used
    localparam logic [63:0] PNOISE_RESET = 64'd655;
    localparam logic [63:0] MNOISE_RESET = 64'd65536;

endpackage

[sv/scalar_kalman_smoother_unit.sv]
// Scalar Kalman smoother: predict, serial gain divide, serial update multiplies.
// A word accepted on s_ gives its estimate on m_ after the predict, gain divide, update
// multiply and finish steps; the divide is skipped when R is zero. One word is worked at a
// time: the next word is taken from the cycle in which that estimate appears. The restoring
// divider (one quotient bit a cycle) and the two shift-add multipliers (one multiplier bit a
// cycle) do the serial work; a result still waiting on m_ holds the finish step until taken.
// Reset (aresetn low, synchronous): estimate 0, variance 1.0, Q = 655, R = 1.0 (Q16.16), no result.
module scalar_kalman_smoother_unit #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF,
    localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // input words
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [TDATA_W-1:0]           s_tdata,   // [DATA_WIDTH-1:0] sample, rest zero

    // result words
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [TDATA_W-1:0]           m_tdata,   // [DATA_WIDTH-1:0] estimate, rest zero

    // configuration writes
    input  logic                         cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data
);

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int CNT_W = $clog2(F + 1);
    localparam int ACC_W = W + F + 2;

    // 1.0 as gain (F+1 bits) and as variance (W bits)
    localparam logic [F:0]   GAIN_ONE = {1'b1, {F{1'b0}}};
    localparam logic [W-1:0] VAR_ONE  = W'(64'd1 << F);

    // sequencer
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a sample
    localparam logic [2:0] ST_PRED  = 3'd1;  // P + Q, saturated
    localparam logic [2:0] ST_DENOM = 3'd2;  // P_pred + R, divider load
    localparam logic [2:0] ST_DIV   = 3'd3;  // one gain bit a cycle
    localparam logic [2:0] ST_MLOAD = 3'd4;  // multiplier load
    localparam logic [2:0] ST_MUL   = 3'd5;  // one multiplier bit a cycle
    localparam logic [2:0] ST_FIN   = 3'd6;  // round, update state, present result

    logic [2:0]       state_reg;
    logic [CNT_W-1:0] cnt_reg;

    // filter state and registers
    logic [W-1:0] est_reg;
    logic [W-1:0] var_reg;
    logic [W-1:0] pnoise_reg;
    logic [W-1:0] mnoise_reg;

    // per-word datapath
    logic [W-1:0]   mag_reg;      // |sample - estimate|
    logic           dir_reg;      // sample >= estimate
    logic [W-1:0]   ppred_reg;
    logic [W:0]     denom_reg;
    logic [W:0]     rem_reg;
    logic [F:0]     quo_reg;      // gain, Q1.F, 1.0 reachable
    logic [F:0]     mfa_reg;      // gain, shifted out LSB first
    logic [F:0]     mfb_reg;      // 1 - gain, shifted out LSB first
    logic [ACC_W-1:0] acca_reg;   // mag * gain
    logic [ACC_W-1:0] accb_reg;   // P_pred * (1 - gain)

    logic           m_valid_reg;
    logic [W-1:0]   out_reg;

    logic           s_acc;
    logic [W-1:0]   samp;
    logic           samp_ge;
    logic [W:0]     psum;
    logic [W+1:0]   rsh;
    logic           qbit;
    logic [W:0]     rem_next;
    logic [W+1:0]   suma;
    logic [W+1:0]   sumb;
    logic [W-1:0]   step;
    logic [W-1:0]   var_next;
    logic [W-1:0]   est_next;
    logic           fin_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(out_reg);

    assign samp    = s_tdata[W-1:0];
    assign samp_ge = ($signed(samp) >= $signed(est_reg));

    assign psum = {1'b0, var_reg} + {1'b0, pnoise_reg};

    // restoring divide step; the dividend bits left are all zero
    assign rsh      = {rem_reg, 1'b0};
    assign qbit     = (rsh >= {1'b0, denom_reg});
    assign rem_next = qbit ? (W+1)'(rsh - {1'b0, denom_reg}) : rsh[W:0];

    // shift-add steps
    assign suma = {1'b0, acca_reg[ACC_W-1:F+1]} + (mfa_reg[0] ? {2'b0, mag_reg}   : '0);
    assign sumb = {1'b0, accb_reg[ACC_W-1:F+1]} + (mfb_reg[0] ? {2'b0, ppred_reg} : '0);

    // round to nearest, half up: floor(x / 2^F) plus bit F-1
    assign step     = acca_reg[F+W-1:F] + W'(acca_reg[F-1]);
    assign var_next = accb_reg[F+W-1:F] + W'(accb_reg[F-1]);
    assign est_next = dir_reg ? (est_reg + step) : (est_reg - step);

    assign fin_go = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            est_reg     <= '0;
            var_reg     <= VAR_ONE;
            pnoise_reg  <= skf_pkg::PNOISE_RESET[W-1:0];
            mnoise_reg  <= skf_pkg::MNOISE_RESET[W-1:0];
        end else begin
            // new result replaces a taken one in the same cycle
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                unique case (cfg_index)
                    skf_pkg::REG_INIT_ESTIMATE: begin
                        est_reg <= cfg_data;
                        var_reg <= VAR_ONE;
                    end
                    skf_pkg::REG_PROCESS_NOISE:     pnoise_reg <= cfg_data;
                    skf_pkg::REG_MEASUREMENT_NOISE: mnoise_reg <= cfg_data;
                    default: ;  // unused index, write dropped
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        state_reg <= ST_PRED;
                    end
                end
                ST_PRED: begin
                    state_reg <= ST_DENOM;
                end
                ST_DENOM: begin
                    cnt_reg   <= '0;
                    // R of zero: gain is 1.0, or 0 when the divisor is zero too
                    state_reg <= (mnoise_reg == '0) ? ST_MLOAD : ST_DIV;
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(F - 1)) begin
                        state_reg <= ST_MLOAD;
                    end
                end
                ST_MLOAD: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(F)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        est_reg   <= est_next;
                        var_reg   <= var_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            dir_reg <= samp_ge;
            mag_reg <= samp_ge ? (samp - est_reg) : (est_reg - samp);
        end
        if (state_reg == ST_PRED) begin
            ppred_reg <= psum[W] ? '1 : psum[W-1:0];
        end
        if (state_reg == ST_DENOM) begin
            denom_reg <= {1'b0, ppred_reg} + {1'b0, mnoise_reg};
            // P_pred < divisor here, so the integer quotient bits are all zero
            rem_reg   <= {1'b0, ppred_reg};
            quo_reg   <= ((mnoise_reg != '0) || (ppred_reg == '0)) ? '0 : GAIN_ONE;
        end
        if (state_reg == ST_DIV) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[F-1:0], qbit};
        end
        if (state_reg == ST_MLOAD) begin
            mfa_reg  <= quo_reg;
            mfb_reg  <= GAIN_ONE - quo_reg;
            acca_reg <= '0;
            accb_reg <= '0;
        end
        if (state_reg == ST_MUL) begin
            acca_reg <= {suma, acca_reg[F:1]};
            accb_reg <= {sumb, accb_reg[F:1]};
            mfa_reg  <= {1'b0, mfa_reg[F:1]};
            mfb_reg  <= {1'b0, mfb_reg[F:1]};
        end
        if (fin_go) begin
            out_reg <= est_next;
        end
    end

endmodule

[sv/skf_checker.sv]
// Port-level checks for the scalar Kalman smoother, bound into the smoother module.
module skf_checker #(
    parameter int TDATA_W = 32
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // one word in flight: taking a word closes the input
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open while a word is being worked");

    // a fresh result coincides with the return to idle
    a_res_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while still busy");

    // reset leaves no result and an open input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the block");

endmodule

bind scalar_kalman_smoother_unit skf_checker #(.TDATA_W(TDATA_W)) u_skf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb_top.sv]
// Self-checking testbench for the scalar Kalman smoother: directed and random sample words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW  = skf_pkg::DATA_WIDTH_DEF;
    localparam int FB  = skf_pkg::FRAC_BITS_DEF;
    localparam int TDW = ((DW + 7) / 8) * 8;

    // spare index: the block must ignore writes to it
    localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [63:0]   DMASK    = (64'd1 << DW) - 64'd1;
    localparam logic [63:0]   ONE_Q    = 64'd1 << FB;
    localparam logic [DW-1:0] ALL_ONES = '1;
    localparam logic [DW-1:0] SIGN_BIT = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] SMAX     = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN     = SIGN_BIT;

    // settle waits longer than one word's run from input to estimate, with margin
    localparam int SETTLE_CYCLES = 2 * FB + 8;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_WORDS   = 136;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [TDW-1:0] s_tdata;    // [DW-1:0] sample
    logic           m_tvalid;
    logic           m_tready;
    logic [TDW-1:0] m_tdata;    // [DW-1:0] estimate
    logic                          cfg_we;
    logic [skf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [DW-1:0]                 cfg_data;

    scalar_kalman_smoother_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter state as the block should hold it
    logic [DW-1:0] est_q;
    logic [DW-1:0] var_q;
    logic [DW-1:0] q_noise;
    logic [DW-1:0] r_noise;

    logic [DW-1:0] expected_estimates[$];
    int            err_count;
    bit            idling_on;
    int            hold_off_cycles;
    int            rx_stall;

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Filter arithmetic
    // ------------------------------------------------------------------

    // round(a * f / 2^FB), half up; a < 2^(DW+1), f <= 2^FB
    function automatic logic [63:0] scale_round(input logic [63:0] a, input logic [63:0] f);
        return (a * f + (ONE_Q >> 1)) >> FB;
    endfunction

    // Advance the filter by one sample and return the new estimate
    task automatic predict_estimate(input logic [DW-1:0] smp, output logic [DW-1:0] est_out);
        logic [63:0] p_pred, denom, gain, xo, zo, mag, stp, newo, pv;
        // predicted variance, clamped at full scale
        p_pred = 64'(var_q) + 64'(q_noise);
        if (p_pred > DMASK)
            p_pred = DMASK;
        denom = p_pred + 64'(r_noise);
        // zero divisor gives zero gain: estimate held, variance = P_pred
        if (denom == 64'd0)
            gain = 64'd0;
        else
            gain = (p_pred << FB) / denom;
        if (gain > ONE_Q)
            gain = ONE_Q;
        // offset binary: signed order becomes unsigned order
        xo = 64'(est_q ^ SIGN_BIT);
        zo = 64'(smp ^ SIGN_BIT);
        if (zo >= xo) begin
            mag = zo - xo;
            stp = scale_round(mag, gain);
            if (stp > mag)
                stp = mag;
            newo = xo + stp;
        end else begin
            mag = xo - zo;
            stp = scale_round(mag, gain);
            if (stp > mag)
                stp = mag;
            newo = xo - stp;
        end
        est_q = DW'(newo) ^ SIGN_BIT;
        pv = scale_round(p_pred, ONE_Q - gain);
        if (pv > p_pred)
            pv = p_pred;
        var_q   = DW'(pv);
        est_out = est_q;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (!idling_on || sel < 50)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        if (sel < 98)
            return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    function automatic logic [DW-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return DW'($urandom);
        if (sel < 70)
            return est_q + DW'($urandom_range(0, 1 << 18)) - DW'(1 << 17);
        if (sel < 80) begin
            case ($urandom_range(0, 3))
                0: return SMIN;
                1: return SMAX;
                2: return '0;
                default: return ALL_ONES;
            endcase
        end
        // single bit away from the estimate
        return est_q ^ (DW'(1) << $urandom_range(0, DW - 1));
    endfunction

    function automatic logic [DW-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_ONES;
            2: return DW'($urandom_range(1, 3));
            3: return DW'($urandom_range(0, 65535));
            4: return DW'($urandom_range(65536, 1 << 20));
            default: return DW'($urandom);
        endcase
    endfunction

    // Called at a falling edge with the block idle
    task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [DW-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
        case (idx)
            skf_pkg::REG_INIT_ESTIMATE: begin
                est_q = val;
                var_q = DW'(ONE_Q);
            end
            skf_pkg::REG_PROCESS_NOISE:     q_noise = val;
            skf_pkg::REG_MEASUREMENT_NOISE: r_noise = val;
            default: ;
        endcase
    endtask

    // Offer one sample word; entered and left at a falling edge
    task automatic send_sample(input logic [DW-1:0] smp);
        int            gap;
        logic [DW-1:0] est_next;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = TDW'(smp);
        do
            @(posedge aclk);
        while (!s_tready);
        predict_estimate(smp, est_next);
        expected_estimates.push_back(est_next);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every estimate, then let the pipe go quiet
    task automatic settle();
        s_tvalid = 1'b0;
        while (expected_estimates.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // settle first, then write
    task automatic write_reg_idle_then(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [DW-1:0] val);
        settle();
        write_reg(idx, val);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset values: estimate 0, variance 1.0, Q = 655, R = 1.0
    task automatic test_reset_values();
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(DW'(32'h0001_0000));
        settle();
    endtask

    // full-scale differences between estimate and sample, both directions
    task automatic test_sample_extremes();
        write_reg(skf_pkg::REG_INIT_ESTIMATE, SMIN);
        send_sample(SMAX);
        settle();
        // R = 0: gain reaches exactly 1.0, estimate jumps to the sample
        write_reg(skf_pkg::REG_INIT_ESTIMATE, SMAX);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, '0);
        send_sample(SMIN);
        settle();
        // R at full scale: tiny gain; then a sample equal to the estimate
        write_reg(skf_pkg::REG_INIT_ESTIMATE, SMAX);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, ALL_ONES);
        send_sample(SMIN);
        send_sample(est_q);
        settle();
    endtask

    // Q at full scale: P + Q clamps at all ones
    task automatic test_variance_saturation();
        write_reg(skf_pkg::REG_PROCESS_NOISE, ALL_ONES);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, DW'(ONE_Q));
        write_reg(skf_pkg::REG_INIT_ESTIMATE, '0);
        send_sample(DW'(32'h0010_0000));
        send_sample(DW'(32'hFFF0_0000));
        write_reg_idle_then(skf_pkg::REG_MEASUREMENT_NOISE, ALL_ONES);
        send_sample(SMAX);
        send_sample(SMIN);
        settle();
    endtask

    // Q = R = 0: first word drives variance to 0, after that the divisor is zero
    task automatic test_zero_divisor();
        write_reg(skf_pkg::REG_PROCESS_NOISE, '0);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, '0);
        write_reg(skf_pkg::REG_INIT_ESTIMATE, DW'(32'h0003_0000));
        send_sample(DW'(32'hFFFE_8000));
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(DW'(32'h1234_5678));
        settle();
    endtask

    // writes to the spare index must change nothing
    task automatic test_unused_index();
        write_reg(skf_pkg::REG_PROCESS_NOISE, DW'(655));
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, DW'(ONE_Q));
        write_reg(REG_UNUSED, ALL_ONES);
        send_sample(DW'(32'h0000_8000));
        write_reg_idle_then(REG_UNUSED, '0);
        send_sample(DW'(32'h8000_0001));
        settle();
    endtask

    // random settings per phase, extremes first; one phase with a long
    // receiver hold-off so the block backs up into its input
    task automatic test_random_phases();
        logic [DW-1:0] init_v;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idling_on = (ph % 4 != 3);
            if (ph == 0) begin
                write_reg(skf_pkg::REG_PROCESS_NOISE, ALL_ONES);
                write_reg(skf_pkg::REG_MEASUREMENT_NOISE, ALL_ONES);
                init_v = SMIN;
            end else if (ph == 1) begin
                write_reg(skf_pkg::REG_PROCESS_NOISE, '0);
                write_reg(skf_pkg::REG_MEASUREMENT_NOISE, '0);
                init_v = SMAX;
            end else begin
                write_reg(skf_pkg::REG_PROCESS_NOISE, pick_noise());
                write_reg(skf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
                init_v = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? SMAX : SMIN)
                                                     : DW'($urandom);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, DW'($urandom));
            write_reg(skf_pkg::REG_INIT_ESTIMATE, init_v);
            if (ph == 5)
                hold_off_cycles = 600;
            for (int k = 0; k < PHASE_WORDS; k++)
                send_sample(pick_sample());
            settle();
        end
        idling_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // m_tready driver: random stalls, plus a requested hold-off counted here
    initial begin
        m_tready = 1'b1;
        rx_stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready = 1'b0;
                hold_off_cycles--;
            end else if (rx_stall > 0) begin
                m_tready = 1'b0;
                rx_stall--;
            end else begin
                m_tready = 1'b1;
                if (idling_on && $urandom_range(0, 3) == 0)
                    rx_stall = pick_gap();
            end
        end
    end

    // compare each accepted estimate word with the oldest prediction
    always @(posedge aclk) begin
        logic [DW-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_estimates.size() == 0) begin
                err_count++;
                $display("%0t: estimate word with none pending: expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = expected_estimates.pop_front();
                if (m_tdata !== TDW'(want)) begin
                    err_count++;
                    $display("%0t: estimate mismatch: expected %h, actual %h",
                             $time, TDW'(want), m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        cfg_we          = 1'b0;
        cfg_index       = skf_pkg::REG_INIT_ESTIMATE;
        cfg_data        = '0;
        err_count       = 0;
        idling_on       = 1'b1;
        hold_off_cycles = 0;
        est_q           = '0;
        var_q           = DW'(ONE_Q);
        q_noise         = skf_pkg::PNOISE_RESET[DW-1:0];
        r_noise         = skf_pkg::MNOISE_RESET[DW-1:0];

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_sample_extremes();
        test_variance_saturation();
        test_zero_divisor();
        test_unused_index();
        test_random_phases();
        settle();

        if (err_count == 0 && expected_estimates.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
